FILE: src/rau_pkg.sv
// Package for the rational arithmetic unit: operand and word widths,
// opcodes, and the input and result item structs. No dependencies.
package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int WORD_BITS    = 32;
    localparam int OP_BITS      = 4;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_GT  = 4'd4,
        OP_LT  = 4'd5,
        OP_EQ  = 4'd6,
        OP_GE  = 4'd7,
        OP_LE  = 4'd8
    } t_op;

    typedef struct packed {
        logic [OP_BITS-1:0]             op;
        logic signed [OPERAND_BITS-1:0] a_num;
        logic signed [OPERAND_BITS-1:0] a_den;
        logic signed [OPERAND_BITS-1:0] b_num;
        logic signed [OPERAND_BITS-1:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] res_num;
        logic signed [WORD_BITS-1:0] res_den;
        logic                        truth;
    } t_res_item;

endpackage

FILE: src/rau_mul.sv
// Shared signed operand multiplier with a registered product, wrapped to
// the result word width. Depends on rau_pkg.
module rau_mul (
    input  logic                                    i_clk,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] i_a,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] i_b,
    output logic signed [rau_pkg::WORD_BITS-1:0]    o_p
);
    import rau_pkg::*;

    localparam int PROD_BITS = 2 * OPERAND_BITS;

    logic signed [PROD_BITS-1:0] w_prod;

    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        o_p <= WORD_BITS'(w_prod);
    end

endmodule

FILE: src/rau_reduce.sv
// Fraction reduction engine: strips common factors of two, runs a binary
// gcd, then divides numerator and denominator by it, restoring, one bit a
// cycle. The gcd loop and both divisions share one subtractor. Depends on rau_pkg.
module rau_reduce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rau_pkg::WORD_BITS-1:0]     i_mag,
    input  logic [rau_pkg::WORD_BITS-1:0]     i_den,
    output logic                              o_done,
    output logic [rau_pkg::WORD_BITS-1:0]     o_mag,
    output logic [rau_pkg::WORD_BITS-1:0]     o_den
);
    import rau_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    typedef enum logic [5:0] {
        RS_IDLE = 6'b000001,
        RS_TWO  = 6'b000010,
        RS_GCD  = 6'b000100,
        RS_DIVN = 6'b001000,
        RS_DIVD = 6'b010000,
        RS_DONE = 6'b100000
    } t_red_state;

    t_red_state           r_state;
    logic [WORD_BITS-1:0] r_n;
    logic [WORD_BITS-1:0] r_d;
    logic [WORD_BITS-1:0] r_x;
    logic [WORD_BITS-1:0] r_y;
    logic [WORD_BITS-1:0] r_rem;
    logic [CNT_BITS-1:0]  r_cnt;

    logic [WORD_BITS-1:0] w_opa;
    logic [WORD_BITS:0]   w_diff;
    logic                 w_ge;
    logic [WORD_BITS-1:0] w_quot;

    always_comb begin
        if (r_state == RS_GCD) begin
            w_opa = r_x;
        end else begin
            w_opa = {r_rem[WORD_BITS-2:0], r_x[WORD_BITS-1]};
        end
    end

    assign w_diff = {1'b0, w_opa} - {1'b0, r_y};
    assign w_ge   = !w_diff[WORD_BITS];
    assign w_quot = {r_x[WORD_BITS-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                RS_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_mag;
                        r_d     <= i_den;
                        r_state <= RS_TWO;
                    end
                end
                RS_TWO: begin
                    if (!r_n[0] && !r_d[0]) begin
                        r_n <= r_n >> 1;
                        r_d <= r_d >> 1;
                    end else begin
                        r_x     <= r_n;
                        r_y     <= r_d;
                        r_state <= RS_GCD;
                    end
                end
                RS_GCD: begin
                    if (w_diff == '0) begin
                        r_x     <= r_n;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= RS_DIVN;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (w_ge) begin
                        r_x <= w_diff[WORD_BITS-1:0];
                    end else begin
                        r_x <= r_y;
                        r_y <= r_x;
                    end
                end
                RS_DIVN, RS_DIVD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != CNT_LAST) begin
                        r_rem <= w_ge ? w_diff[WORD_BITS-1:0] : w_opa;
                        r_x   <= w_quot;
                    end else if (r_state == RS_DIVN) begin
                        r_n     <= w_quot;
                        r_x     <= r_d;
                        r_rem   <= '0;
                        r_state <= RS_DIVD;
                    end else begin
                        r_d     <= w_quot;
                        r_state <= RS_DONE;
                    end
                end
                RS_DONE: begin
                    r_state <= RS_IDLE;
                end
                default: begin
                    r_state <= RS_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == RS_DONE);
    assign o_mag  = r_n;
    assign o_den  = r_d;

endmodule

FILE: src/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: item sequencer, cross products on the
// shared multiplier, compares, and hand-off to the reduction engine.
// Depends on rau_pkg, rau_mul and rau_reduce.
//
// Usage: drive i_item and raise i_start while o_busy is low; the item is
// taken at that clock edge and o_busy stays high until the result is out.
// The result appears on o_result for exactly one cycle with o_valid high;
// the receiver cannot hold it off, and a new item may start in that cycle.
// Sequence: five products on one multiplier, then the result is formed.
// Compares, unused opcodes and arithmetic results with a zero numerator
// or a zero or negative denominator finish there. Otherwise reduction
// strips common halves, runs the binary gcd loop (shift, subtract or swap
// on the shared subtractor), does two restoring divisions and hands the
// result back.
// Reset (synchronous, active low) returns the sequencers to idle and drops
// o_valid; no item in progress survives it.
module rational_arithmetic_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rau_pkg::t_in_item    i_item,
    output logic                 o_busy,
    output logic                 o_valid,
    output rau_pkg::t_res_item   o_result
);
    import rau_pkg::*;

    localparam int NUM_PROD = 5;
    localparam int PCNT_BITS = $clog2(NUM_PROD + 1);
    localparam logic [PCNT_BITS-1:0] PCNT_LAST = PCNT_BITS'(NUM_PROD);
    localparam logic [PCNT_BITS-1:0] P_LHS = PCNT_BITS'(0);
    localparam logic [PCNT_BITS-1:0] P_RHS = PCNT_BITS'(1);
    localparam logic [PCNT_BITS-1:0] P_DD  = PCNT_BITS'(2);
    localparam logic [PCNT_BITS-1:0] P_NN  = PCNT_BITS'(3);
    localparam logic [PCNT_BITS-1:0] P_X   = PCNT_BITS'(4);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_FORM = 4'b0100,
        ST_RED  = 4'b1000
    } t_state;

    t_state                       r_state;
    t_in_item                     r_in;
    logic [PCNT_BITS-1:0]         r_cnt;
    logic signed [WORD_BITS-1:0]  r_prod [NUM_PROD];
    logic                         r_neg;
    logic                         r_valid;
    t_res_item                    r_out;

    logic signed [OPERAND_BITS-1:0] w_ma;
    logic signed [OPERAND_BITS-1:0] w_mb;
    logic signed [WORD_BITS-1:0]    w_p;
    logic signed [WORD_BITS-1:0]    w_lhs;
    logic signed [WORD_BITS-1:0]    w_rhs;
    logic [WORD_BITS-1:0]           w_num;
    logic [WORD_BITS-1:0]           w_den;
    logic [WORD_BITS-1:0]           w_mag;
    logic                           w_truth;
    logic                           w_arith;
    logic                           w_skip;
    logic                           w_red_start;
    logic                           w_red_done;
    logic [WORD_BITS-1:0]           w_red_mag;
    logic [WORD_BITS-1:0]           w_red_den;

    always_comb begin
        case (r_cnt)
            P_LHS:   begin w_ma = r_in.a_num; w_mb = r_in.b_den; end
            P_RHS:   begin w_ma = r_in.b_num; w_mb = r_in.a_den; end
            P_DD:    begin w_ma = r_in.a_den; w_mb = r_in.b_den; end
            P_NN:    begin w_ma = r_in.a_num; w_mb = r_in.b_num; end
            P_X:     begin w_ma = r_in.a_den; w_mb = r_in.b_num; end
            default: begin w_ma = r_in.a_num; w_mb = r_in.b_den; end
        endcase
    end

    rau_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    assign w_lhs = r_prod[P_LHS];
    assign w_rhs = r_prod[P_RHS];

    always_comb begin
        w_num   = '0;
        w_den   = '0;
        w_truth = 1'b0;
        w_arith = 1'b0;
        unique case (r_in.op)
            OP_ADD: begin
                w_num = w_lhs + w_rhs;  w_den = r_prod[P_DD]; w_arith = 1'b1;
            end
            OP_SUB: begin
                w_num = w_lhs - w_rhs;  w_den = r_prod[P_DD]; w_arith = 1'b1;
            end
            OP_MUL: begin
                w_num = r_prod[P_NN];   w_den = r_prod[P_DD]; w_arith = 1'b1;
            end
            OP_DIV: begin
                w_num = w_lhs;          w_den = r_prod[P_X];  w_arith = 1'b1;
            end
            OP_GT: w_truth = (w_rhs < w_lhs);
            OP_LT: w_truth = (w_lhs < w_rhs);
            OP_EQ: w_truth = (r_in.a_num == r_in.b_num) && (r_in.a_den == r_in.b_den);
            OP_GE: w_truth = !(w_lhs < w_rhs);
            OP_LE: w_truth = !(w_rhs < w_lhs);
            default: w_truth = 1'b0;
        endcase
    end

    assign w_skip      = (w_num == '0) || (w_den == '0) || w_den[WORD_BITS-1];
    assign w_mag       = w_num[WORD_BITS-1] ? (~w_num + 1'b1) : w_num;
    assign w_red_start = (r_state == ST_FORM) && w_arith && !w_skip;

    rau_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_red_start),
        .i_mag   (w_mag),
        .i_den   (w_den),
        .o_done  (w_red_done),
        .o_mag   (w_red_mag),
        .o_den   (w_red_den)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= ((r_state == ST_FORM) && !w_red_start) ||
                       ((r_state == ST_RED) && w_red_done);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_in    <= i_item;
                        r_cnt   <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_cnt != '0) begin
                        r_prod[r_cnt - 1'b1] <= w_p;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == PCNT_LAST) begin
                        r_state <= ST_FORM;
                    end
                end
                ST_FORM: begin
                    if (w_red_start) begin
                        r_neg   <= w_num[WORD_BITS-1];
                        r_state <= ST_RED;
                    end else begin
                        r_out.res_num <= w_num;
                        r_out.res_den <= w_den;
                        r_out.truth   <= w_truth;
                        r_state       <= ST_IDLE;
                    end
                end
                ST_RED: begin
                    if (w_red_done) begin
                        r_out.res_num <= r_neg ? (~w_red_mag + 1'b1) : w_red_mag;
                        r_out.res_den <= w_red_den;
                        r_out.truth   <= 1'b0;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule
